/* hw/rtl/lzwd_pkg.sv */
package lzwd_pkg;

  typedef enum logic [1:0] {
    PH_TABLE,
    PH_HEADER,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_SYM,
    ST_FLUSH
  } state_t;

  // Table write request towards the symbol store
  typedef struct packed {
    logic we;
    logic [15:0] data;
  } tab_wr_t;

  localparam int TABLE_DEPTH_DEF = 512;

  localparam logic       KIND_START        = 1'b0;
  localparam logic       CFG_TABLE_ENTRIES = 1'b0;
  localparam logic       CFG_OUTPUT_WORDS  = 1'b1;

  localparam logic [2:0] NO_CMD   = 3'd4;
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_INC1 = 2'd1;
  localparam logic [1:0] CMD_INC2 = 2'd2;

  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_WIDTH = 2'd1;
  localparam logic [1:0] ESC_LIT   = 2'd2;

  localparam logic [3:0]  LIT_SHORT = 4'd8;
  localparam logic [3:0]  LIT_LONG  = 4'd12;
  localparam logic [15:0] ESC_ADD   = 16'h7f02;

endpackage

/* hw/rtl/lzwd_symtab.sv */
module lzwd_symtab #(
  parameter int DEPTH = lzwd_pkg::TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  lzwd_pkg::tab_wr_t        wr,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [15:0]              rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.data;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/prefix_code_lz_word_decoder_top.sv */
// Prefix-code word decoder with escaped literals.
// Input channel: in_tdata carries a 16-bit compressed word, in_tuser the kind.
// Kind 0 starts a job (counters reloaded from configuration, no result);
// kind 1 hands a word whose bits are consumed most significant first.
// Output channel: out_tdata is the decoded word, out_tlast marks the last
// item caused by an input word, out_tuser marks the item that ends the job.
// Configuration: cfg_index 0 = table entries, 1 = output words; write only
// while idle (in_tready high and all items delivered).
// Flow: the bit reader takes one bit per cycle unless the output stalls. A
// word is accepted, its 16 bits are read, each zero-bit table command and
// each table lookup takes a step of its own, then the word is found empty
// and the final item is handed over. Once the job has ended a word is only
// accepted and found empty; a start item is taken while idle. in_tready is
// high only between words. Up to eight items may come from one word.
// Results are held one deep inside and passed through an output register;
// while the receiver stalls, decoding halts at the next item it must emit.
// Reset (rst_n low, synchronous) empties the output and returns to the table
// phase with zero counters; table contents are kept. TABLE_DEPTH is a power
// of two; indexes wrap modulo it.
module prefix_code_lz_word_decoder_top #(
  parameter int TABLE_DEPTH = lzwd_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // packed_word
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // decoded_word
  output logic        out_tlast,  // last_of_run
  output logic        out_tuser,  // job_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  lzwd_pkg::state_t state_r, state_nxt;
  lzwd_pkg::phase_t phase_r, phase_nxt;

  logic [9:0]  te_r;
  logic [15:0] ow_r;
  logic [15:0] buf_r, buf_nxt;
  logic [4:0]  avail_r, avail_nxt;
  logic [3:0]  fbl_r, fbl_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [2:0]  pcmd_r, pcmd_nxt;
  logic [15:0] rsym_r, rsym_nxt;
  logic [9:0]  eidx_r, eidx_nxt;
  logic [1:0]  sw_r, sw_nxt;
  logic [3:0]  grem_r, grem_nxt;
  logic [3:0]  cg_r, cg_nxt;
  logic [1:0]  esc_r, esc_nxt;
  logic [3:0]  litw_r, litw_nxt;
  logic [9:0]  erem_r, erem_nxt;
  logic [15:0] orem_r, orem_nxt;
  logic [3:0]  glen_r [8];
  logic [15:0] goff_r [8];

  logic        pend_v_r, pend_v_nxt;
  logic [15:0] pend_word_r, pend_word_nxt;
  logic        pend_done_r, pend_done_nxt;
  logic        out_v_r;
  logic [15:0] out_word_r;
  logic        out_last_r, out_done_r;

  logic        out_load, out_last_load, out_free;
  logic        g_we;
  logic [3:0]  g_len;
  logic [3:0]  need, eff_left, left;
  logic [11:0] eff_acc, val;
  logic        done_f, word_end, go_sym, stall;
  logic        emit_req, emit_cnt, emit_done;
  logic [15:0] emit_word, sym, rsym_new;
  logic [15:0] orem_dec;
  logic [16:0] rd_sum, wr_ext;
  logic        start;
  logic        rd_re;
  logic [15:0] rd_data;
  lzwd_pkg::tab_wr_t tab_wr;

  assign in_tready = (state_r == lzwd_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign start     = in_tvalid && in_tready;
  assign out_free  = !out_v_r || out_tready;
  assign sym       = rd_data;
  assign orem_dec  = orem_r - 16'd1;

  assign rd_sum = {1'b0, goff_r[cg_r[2:0]]} + {5'd0, val};
  assign wr_ext = {7'd0, eidx_r};

  lzwd_symtab #(
    .DEPTH(TABLE_DEPTH)
  ) u_symtab (
    .clk  (clk),
    .wr   (tab_wr),
    .waddr(wr_ext[AW-1:0]),
    .re   (rd_re),
    .raddr(rd_sum[AW-1:0]),
    .rdata(rd_data)
  );

  // Field width wanted by the current step
  always_comb begin
    need = 4'd0;
    unique case (phase_r)
      lzwd_pkg::PH_TABLE: begin
        if (pcmd_r == lzwd_pkg::NO_CMD) begin
          need = 4'd2;
        end else begin
          unique case (pcmd_r[1:0])
            lzwd_pkg::CMD_LOAD: need = 4'd9;
            lzwd_pkg::CMD_INC1: need = 4'd0;
            lzwd_pkg::CMD_INC2: need = 4'd1;
            default:            need = 4'd4;
          endcase
        end
      end
      lzwd_pkg::PH_HEADER: need = (sw_r == 2'd0) ? 4'd1 : 4'd3;
      lzwd_pkg::PH_DATA: begin
        priority if (esc_r == lzwd_pkg::ESC_WIDTH) begin
          need = 4'd1;
        end else if (esc_r == lzwd_pkg::ESC_LIT) begin
          need = litw_r;
        end else if (cg_r[3]) begin
          need = {2'd0, sw_r};
        end else begin
          need = glen_r[cg_r[2:0]];
        end
      end
      default: need = 4'd0;
    endcase
  end

  // One bit a cycle through the field accumulator unless the output stalls
  always_comb begin
    eff_left = (fbl_r == 4'd0) ? need : fbl_r;
    eff_acc  = (fbl_r == 4'd0) ? 12'd0 : acc_r;
    word_end = (phase_r == lzwd_pkg::PH_DONE) || (eff_left != 4'd0 && avail_r == 5'd0);
    if (eff_left != 4'd0) begin
      val  = {eff_acc[10:0], buf_r[15]};
      left = eff_left - 4'd1;
    end else begin
      val  = eff_acc;
      left = 4'd0;
    end
    done_f = (left == 4'd0);
  end

  always_comb begin
    emit_req  = 1'b0;
    emit_cnt  = 1'b1;
    emit_word = {4'd0, val};
    if (state_r == lzwd_pkg::ST_SYM) begin
      emit_req = 1'b1;
      if (sym[15:8] != 8'd0) begin
        emit_cnt  = 1'b0;
        emit_word = sym + lzwd_pkg::ESC_ADD;
      end else begin
        emit_word = sym;
      end
    end else if (state_r == lzwd_pkg::ST_STEP && !word_end && done_f &&
                 phase_r == lzwd_pkg::PH_DATA && esc_r == lzwd_pkg::ESC_LIT) begin
      emit_req = 1'b1;
    end
    stall     = emit_req && pend_v_r && !out_free;
    emit_done = emit_cnt && (orem_dec == 16'd0);
    go_sym    = (state_r == lzwd_pkg::ST_STEP) && !word_end && done_f &&
                phase_r == lzwd_pkg::PH_DATA && esc_r == lzwd_pkg::ESC_NONE && !cg_r[3];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lzwd_pkg::ST_IDLE: begin
        if (start && in_tuser != lzwd_pkg::KIND_START) begin
          state_nxt = lzwd_pkg::ST_STEP;
        end
      end
      lzwd_pkg::ST_STEP: begin
        priority if (word_end) begin
          state_nxt = lzwd_pkg::ST_FLUSH;
        end else if (go_sym) begin
          state_nxt = lzwd_pkg::ST_SYM;
        end
      end
      lzwd_pkg::ST_SYM: begin
        if (!stall) begin
          state_nxt = lzwd_pkg::ST_STEP;
        end
      end
      default: begin
        if (!pend_v_r || out_free) begin
          state_nxt = lzwd_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Datapath updates
  always_comb begin
    phase_nxt = phase_r;   buf_nxt  = buf_r;   avail_nxt = avail_r;
    fbl_nxt   = fbl_r;     acc_nxt  = acc_r;   pcmd_nxt  = pcmd_r;
    rsym_nxt  = rsym_r;    eidx_nxt = eidx_r;  sw_nxt    = sw_r;
    grem_nxt  = grem_r;    cg_nxt   = cg_r;    esc_nxt   = esc_r;
    litw_nxt  = litw_r;    erem_nxt = erem_r;  orem_nxt  = orem_r;
    pend_v_nxt = pend_v_r; pend_word_nxt = pend_word_r; pend_done_nxt = pend_done_r;
    out_load = 1'b0; out_last_load = 1'b0;
    g_we = 1'b0; g_len = val[3:0] + 4'd1;
    tab_wr.we = 1'b0; rd_re = 1'b0;
    rsym_new = rsym_r;
    unique case (pcmd_r[1:0])
      lzwd_pkg::CMD_LOAD: rsym_new = {7'd0, val[8:0]};
      lzwd_pkg::CMD_INC1: rsym_new = rsym_r + 16'd1;
      lzwd_pkg::CMD_INC2: rsym_new = rsym_r + 16'd2 + {15'd0, val[0]};
      default:            rsym_new = rsym_r + 16'd4 + {12'd0, val[3:0]};
    endcase
    tab_wr.data = rsym_new;

    unique case (state_r)
      lzwd_pkg::ST_IDLE: begin
        if (start) begin
          if (in_tuser == lzwd_pkg::KIND_START) begin
            phase_nxt = lzwd_pkg::PH_TABLE;
            fbl_nxt = 4'd0; acc_nxt = 12'd0; pcmd_nxt = lzwd_pkg::NO_CMD;
            rsym_nxt = 16'd0; eidx_nxt = 10'd0; sw_nxt = 2'd0; grem_nxt = 4'd0;
            cg_nxt = 4'd8; esc_nxt = lzwd_pkg::ESC_NONE; litw_nxt = 4'd0;
            erem_nxt = te_r; orem_nxt = ow_r;
          end else begin
            buf_nxt = in_tdata; avail_nxt = 5'd16;
          end
        end
      end
      lzwd_pkg::ST_STEP: begin
        if (word_end) begin
          fbl_nxt = eff_left; acc_nxt = eff_acc;
        end else if (!stall) begin
          fbl_nxt = left; acc_nxt = val;
          if (eff_left != 4'd0) begin
            buf_nxt = {buf_r[14:0], 1'b0}; avail_nxt = avail_r - 5'd1;
          end
          if (done_f) begin
            unique case (phase_r)
              lzwd_pkg::PH_TABLE: begin
                if (pcmd_r == lzwd_pkg::NO_CMD) begin
                  pcmd_nxt = {1'b0, val[1:0]};
                end else begin
                  tab_wr.we = 1'b1;
                  pcmd_nxt = lzwd_pkg::NO_CMD;
                  rsym_nxt = rsym_new;
                  eidx_nxt = eidx_r + 10'd1;
                  erem_nxt = erem_r - 10'd1;
                  if (erem_nxt == 10'd0) begin
                    phase_nxt = lzwd_pkg::PH_HEADER;
                    eidx_nxt = 10'd0; rsym_nxt = 16'd0; sw_nxt = 2'd0; grem_nxt = 4'd0;
                  end
                end
              end
              lzwd_pkg::PH_HEADER: begin
                if (sw_r == 2'd0) begin
                  sw_nxt   = val[0] ? 2'd3 : 2'd2;
                  grem_nxt = val[0] ? 4'd8 : 4'd4;
                  eidx_nxt = 10'd0;
                end else begin
                  g_we = 1'b1;
                  eidx_nxt = eidx_r + 10'd1;
                  rsym_nxt = rsym_r + (16'd1 << g_len);
                  grem_nxt = grem_r - 4'd1;
                  if (grem_nxt == 4'd0) begin
                    phase_nxt = lzwd_pkg::PH_DATA;
                    cg_nxt = 4'd8; esc_nxt = lzwd_pkg::ESC_NONE;
                  end
                end
              end
              lzwd_pkg::PH_DATA: begin
                priority if (esc_r == lzwd_pkg::ESC_WIDTH) begin
                  litw_nxt = val[0] ? lzwd_pkg::LIT_LONG : lzwd_pkg::LIT_SHORT;
                  esc_nxt  = lzwd_pkg::ESC_LIT;
                end else if (esc_r == lzwd_pkg::ESC_LIT) begin
                  esc_nxt = lzwd_pkg::ESC_NONE;
                end else if (cg_r[3]) begin
                  cg_nxt = {1'b0, val[2:0]};
                end else begin
                  rd_re = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      lzwd_pkg::ST_SYM: begin
        if (!stall) begin
          cg_nxt = 4'd8;
          if (!emit_cnt) begin
            esc_nxt = lzwd_pkg::ESC_WIDTH;
          end
        end
      end
      default: begin
        if (pend_v_r && out_free) begin
          out_load = 1'b1; out_last_load = 1'b1; pend_v_nxt = 1'b0;
        end
      end
    endcase

    // Hand the held item on and keep the new one until the word's end is known
    if (emit_req && !stall) begin
      if (emit_cnt) begin
        orem_nxt = orem_dec;
        if (emit_done) begin
          phase_nxt = lzwd_pkg::PH_DONE;
        end
      end
      if (pend_v_r) begin
        out_load = 1'b1;
      end
      pend_v_nxt = 1'b1; pend_word_nxt = emit_word; pend_done_nxt = emit_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lzwd_pkg::ST_IDLE;
      phase_r <= lzwd_pkg::PH_TABLE;
      te_r <= 10'd1; ow_r <= 16'd1;
      avail_r <= 5'd0; fbl_r <= 4'd0; acc_r <= 12'd0; buf_r <= 16'd0;
      pcmd_r <= lzwd_pkg::NO_CMD; rsym_r <= 16'd0; eidx_r <= 10'd0;
      sw_r <= 2'd0; grem_r <= 4'd0; cg_r <= 4'd8; esc_r <= lzwd_pkg::ESC_NONE;
      litw_r <= 4'd0; erem_r <= 10'd0; orem_r <= 16'd0;
      pend_v_r <= 1'b0; out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt; phase_r <= phase_nxt;
      avail_r <= avail_nxt; fbl_r <= fbl_nxt; acc_r <= acc_nxt; buf_r <= buf_nxt;
      pcmd_r <= pcmd_nxt; rsym_r <= rsym_nxt; eidx_r <= eidx_nxt;
      sw_r <= sw_nxt; grem_r <= grem_nxt; cg_r <= cg_nxt; esc_r <= esc_nxt;
      litw_r <= litw_nxt; erem_r <= erem_nxt; orem_r <= orem_nxt;
      pend_v_r <= pend_v_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lzwd_pkg::CFG_TABLE_ENTRIES) begin
          te_r <= cfg_data[9:0];
        end else begin
          ow_r <= cfg_data;
        end
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_word_r <= pend_word_nxt;
    pend_done_r <= pend_done_nxt;
    if (out_load) begin
      out_word_r <= pend_word_r;
      out_done_r <= pend_done_r;
      out_last_r <= out_last_load;
    end
    if (g_we) begin
      glen_r[eidx_r[2:0]] <= g_len;
      goff_r[eidx_r[2:0]] <= rsym_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_word_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

  a_idle_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lzwd_pkg::ST_IDLE) |-> !pend_v_r)
    else $error("held item left behind after word end");

  a_avail_range : assert property (@(posedge clk) disable iff (!rst_n)
    avail_r <= 5'd16)
    else $error("bit count beyond one word");

  a_sym_in_data : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lzwd_pkg::ST_SYM) |-> (phase_r == lzwd_pkg::PH_DATA && !cg_r[3]))
    else $error("table lookup outside data phase");

  a_load_free : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("output register overwritten");

endmodule
